// ----- rtl/rbpe_pkg.sv -----
`default_nettype none
package rbpe_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BASIS_W   = FRAC_BITS + 1;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned WEIGHT_W  = 24;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned PARAM_W   = 17;
  localparam int unsigned PT_W      = 3 * COORD_W + WEIGHT_W;
  localparam int unsigned MUL_A_W   = COORD_W + 1;
  localparam int unsigned MUL_B_W   = WEIGHT_W + 2;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned WB_W      = WEIGHT_W + 1;
  localparam int unsigned ACC_W     = 61;
  localparam int unsigned SW_W      = 29;
  localparam int unsigned DVD_W     = 62;
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [BASIS_W-1:0] ONE_F = BASIS_W'(1) << FRAC_BITS;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_INIT   = 16'h0002,
    ST_B_RD   = 16'h0004,
    ST_B_M1   = 16'h0008,
    ST_B_M2   = 16'h0010,
    ST_B_CY   = 16'h0020,
    ST_A_RD   = 16'h0040,
    ST_A_WB   = 16'h0080,
    ST_A_WR   = 16'h0100,
    ST_A_X    = 16'h0200,
    ST_A_Y    = 16'h0400,
    ST_A_Z    = 16'h0800,
    ST_A_N    = 16'h1000,
    ST_D_GO   = 16'h2000,
    ST_D_WAIT = 16'h4000,
    ST_FIN    = 16'h8000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/rational_bezier_point_eval_unit.sv -----
`default_nettype none
// Rational Bezier curve evaluator.
// Input stream: tuser = op (0 load a control point, 1 evaluate). A load writes
// point_index/x/y/z/weight into the point store in the cycle it is accepted and
// gives no result. An evaluate computes all Bernstein basis values of the
// configured degree n, weighted sums and three quotients, and returns one
// result transaction: tdata = x, y, z (signed Q16.16), tuser = zero_weight.
// Everything runs on one shared 33x26 multiplier and one bit-serial divider.
// A zero weight sum skips the divider. The divider's 62 steps per coordinate
// dominate at low degree, the basis recurrence at high degree.
// The input is not ready while an evaluation runs; one item at a time, the next
// evaluate can be accepted once the previous result is registered.
// A finished result sits in the output register until taken; the next
// evaluation may run meanwhile and waits at its end if the register is full.
// The user writes the degree (cfg_we_i, reset 3) only while the block is idle; not enforced.
// Reset clears control state only; the point store is undefined until loaded.
module rational_bezier_point_eval_unit #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [3:0]                          cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // point_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
  // point_weight[123:100], param_t[140:124], zero pad
  input  wire logic [rbpe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // curve_x[31:0], curve_y[63:32], curve_z[95:64]
  output logic      [rbpe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // zero_weight
  output logic                                     m_axis_tuser
);
  import rbpe_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  state_e state_q, state_d;

  logic [3:0]           degree_q;
  logic [AW-1:0]        n_q, j_q, k_q;
  logic [1:0]           c_q;
  logic [BASIS_W-1:0]   t_q, t1, prev_q, carry_q;
  logic [WB_W-1:0]      wb_q;
  logic [SW_W-1:0]      sw_q;
  logic signed [ACC_W-1:0] sx_q, sy_q, sz_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_q;
  logic [COORD_W-1:0]   res_x_q, res_y_q, res_z_q;
  logic                 zw_q, neg_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                 out_user_q;

  // input fields
  logic [IDX_W-1:0]     in_idx;
  logic [PARAM_W-1:0]   in_t;
  logic [PT_W-1:0]      in_pt;
  logic                 accept, load_we;

  // memories
  logic [PT_W-1:0]      pt_rdata;
  logic [BASIS_W-1:0]   bs_rdata, bs_wdata;
  logic                 bs_we, rd_en;
  logic [AW-1:0]        bs_waddr;

  // arithmetic
  logic [BASIS_W-1:0]   bas_rnd;
  logic [BASIS_W:0]     bas_sum;
  logic [BASIS_W-1:0]   bas_sat;
  logic [WB_W-1:0]      wb_rnd;
  logic signed [ACC_W-1:0] num_sel;
  logic [ACC_W-1:0]     mag;
  logic [DVD_W-1:0]     dividend;
  logic                 div_start, div_done;
  logic [DVD_W-1:0]     quot;
  logic [COORD_W-1:0]   q_sat;
  logic [COORD_W-1:0]   pt_x, pt_y, pt_z;
  logic [WEIGHT_W-1:0]  pt_w;
  logic [6:0]           n_clamp;

  assign in_idx = s_axis_tdata[3:0];
  assign in_pt  = s_axis_tdata[123:4];
  assign in_t   = s_axis_tdata[140:124];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_we       = accept && (op_e'(s_axis_tuser) == OP_LOAD)
                         && (32'(in_idx) < MAX_POINTS);

  assign {pt_w, pt_z, pt_y, pt_x} = pt_rdata;

  assign t1 = ONE_F - t_q;
  assign n_clamp = (7'(degree_q) > 7'(MAX_POINTS - 1)) ? 7'(MAX_POINTS - 1)
                                                       : 7'(degree_q);

  // round half up at FRAC_BITS
  assign bas_rnd = BASIS_W'((mul_q[2*BASIS_W-1:0] + (2*BASIS_W)'(1 << (FRAC_BITS - 1)))
                            >> FRAC_BITS);
  assign bas_sum = (BASIS_W + 1)'(carry_q) + (BASIS_W + 1)'(bas_rnd);
  assign bas_sat = (bas_sum > (BASIS_W + 1)'(ONE_F)) ? ONE_F : BASIS_W'(bas_sum);
  assign wb_rnd  = WB_W'((mul_q[WEIGHT_W+BASIS_W-1:0]
                          + (WEIGHT_W + BASIS_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_B_M1: begin
        mul_a = MUL_A_W'(t1);
        mul_b = MUL_B_W'(bs_rdata);
      end
      ST_B_M2: begin
        mul_a = MUL_A_W'(t_q);
        mul_b = MUL_B_W'(prev_q);
      end
      ST_A_WB: begin
        mul_a = MUL_A_W'(pt_w);
        mul_b = MUL_B_W'(bs_rdata);
      end
      ST_A_X: begin
        mul_a = {pt_x[COORD_W-1], pt_x};
        mul_b = MUL_B_W'(wb_q);
      end
      ST_A_Y: begin
        mul_a = {pt_y[COORD_W-1], pt_y};
        mul_b = MUL_B_W'(wb_q);
      end
      ST_A_Z: begin
        mul_a = {pt_z[COORD_W-1], pt_z};
        mul_b = MUL_B_W'(wb_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // basis store write port
  always_comb begin
    bs_we    = 1'b0;
    bs_waddr = k_q;
    bs_wdata = bas_sat;
    case (state_q)
      ST_INIT: begin
        bs_we    = 1'b1;
        bs_waddr = '0;
        bs_wdata = ONE_F;
      end
      ST_B_M2: begin
        bs_we = 1'b1;
      end
      ST_B_CY: begin
        bs_we    = (k_q == AW'(j_q - 1'b1));
        bs_waddr = j_q;
        bs_wdata = (bas_rnd > ONE_F) ? ONE_F : bas_rnd;
      end
      default: bs_we = 1'b0;
    endcase
  end

  assign rd_en = (state_q == ST_B_RD) || (state_q == ST_A_RD);

  rbpe_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(AW'(in_idx)),
    .wdata_i(in_pt),
    .re_i   (state_q == ST_A_RD),
    .raddr_i(k_q),
    .rdata_o(pt_rdata)
  );

  rbpe_ram #(.WIDTH(BASIS_W), .DEPTH(MAX_POINTS)) u_basis_ram (
    .clk_i  (clk_i),
    .we_i   (bs_we),
    .waddr_i(bs_waddr),
    .wdata_i(bs_wdata),
    .re_i   (rd_en),
    .raddr_i(k_q),
    .rdata_o(bs_rdata)
  );

  // divider operand: |num| + sw/2, rounding ties away from zero
  always_comb begin
    case (c_q)
      2'd0:    num_sel = sx_q;
      2'd1:    num_sel = sy_q;
      default: num_sel = sz_q;
    endcase
    mag      = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : ACC_W'(num_sel);
    dividend = DVD_W'(mag) + DVD_W'(sw_q >> 1);
  end

  assign div_start = (state_q == ST_D_GO) && (sw_q != '0);

  rbpe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (sw_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    if (neg_q) begin
      q_sat = (quot > DVD_W'(33'h080000000)) ? 32'h80000000 : COORD_W'(-quot);
    end else begin
      q_sat = (quot > DVD_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : COORD_W'(quot);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && op_e'(s_axis_tuser) == OP_EVAL) state_d = ST_INIT;
      ST_INIT: state_d = (n_q == '0) ? ST_A_RD : ST_B_RD;
      ST_B_RD: state_d = ST_B_M1;
      ST_B_M1: state_d = ST_B_M2;
      ST_B_M2: state_d = ST_B_CY;
      ST_B_CY: begin
        if (k_q == AW'(j_q - 1'b1) && j_q == n_q) state_d = ST_A_RD;
        else state_d = ST_B_RD;
      end
      ST_A_RD: state_d = ST_A_WB;
      ST_A_WB: state_d = ST_A_WR;
      ST_A_WR: state_d = ST_A_X;
      ST_A_X:  state_d = ST_A_Y;
      ST_A_Y:  state_d = ST_A_Z;
      ST_A_Z:  state_d = ST_A_N;
      ST_A_N:  state_d = (k_q == n_q) ? ST_D_GO : ST_A_RD;
      ST_D_GO: state_d = (sw_q == '0) ? ST_FIN : ST_D_WAIT;
      ST_D_WAIT: begin
        if (div_done) state_d = (c_q == 2'd2) ? ST_FIN : ST_D_GO;
      end
      ST_FIN:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      degree_q    <= 4'd3;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) degree_q <= cfg_wdata_i;
      if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        t_q <= (in_t > PARAM_W'(ONE_F)) ? ONE_F : BASIS_W'(in_t);
        n_q <= AW'(n_clamp);
      end
      ST_INIT: begin
        j_q     <= AW'(1);
        k_q     <= '0;
        carry_q <= '0;
        sw_q    <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        sz_q    <= '0;
        c_q     <= '0;
        zw_q    <= 1'b0;
      end
      ST_B_M1: prev_q <= bs_rdata;
      ST_B_CY: begin
        if (k_q == AW'(j_q - 1'b1)) begin
          carry_q <= '0;
          k_q     <= '0;
          if (j_q != n_q) j_q <= j_q + 1'b1;
        end else begin
          carry_q <= bas_rnd;
          k_q     <= k_q + 1'b1;
        end
      end
      ST_A_WR: begin
        wb_q <= wb_rnd;
        sw_q <= sw_q + SW_W'(wb_rnd);
      end
      ST_A_Y: sx_q <= sx_q + ACC_W'(mul_q);
      ST_A_Z: sy_q <= sy_q + ACC_W'(mul_q);
      ST_A_N: begin
        sz_q <= sz_q + ACC_W'(mul_q);
        if (k_q != n_q) k_q <= k_q + 1'b1;
      end
      ST_D_GO: begin
        neg_q <= num_sel[ACC_W-1];
        if (sw_q == '0) begin
          zw_q    <= 1'b1;
          res_x_q <= '0;
          res_y_q <= '0;
          res_z_q <= '0;
        end
      end
      ST_D_WAIT: begin
        if (div_done) begin
          case (c_q)
            2'd0:    res_x_q <= q_sat;
            2'd1:    res_y_q <= q_sat;
            default: res_z_q <= q_sat;
          endcase
          c_q <= c_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {res_z_q, res_y_q, res_x_q};
          out_user_q <= zw_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// ----- rtl/rbpe_ram.sv -----
`default_nettype none
module rbpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rbpe_div.sv -----
`default_nettype none
module rbpe_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rbpe_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [rbpe_pkg::SW_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic      [rbpe_pkg::DVD_W-1:0]  quot_o
);
  import rbpe_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [SW_W-1:0]  den_q;
  logic [SW_W-1:0]  rem_q, rem_d;
  logic [SW_W:0]    rem_sh;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             bit_ok;

  // restoring division, one quotient bit per cycle; quotient shifts into dvd_q
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    bit_ok = rem_sh >= {1'b0, den_q};
    rem_d  = bit_ok ? SW_W'(rem_sh - {1'b0, den_q}) : SW_W'(rem_sh);
    dvd_d  = {dvd_q[DVD_W-2:0], bit_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire
